// ===== rtl/assert_macros.svh =====
// Assertion macros for the fast inverse square root unit.
// No dependencies; taken in by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/fisqrt_pkg.sv =====
// Shared constants and float helpers for the fast inverse square root unit.
// No dependencies.
package fisqrt_pkg;
    localparam logic [31:0] MAGIC_SEED = 32'h5f375a86;
    localparam logic [31:0] CANON_NAN = 32'h7fc00000;
    localparam logic [31:0] HALF_F = 32'h3f000000;
    localparam logic [31:0] THREE_HALVES_F = 32'h3fc00000;
    localparam int unsigned LATENCY = 11;

    typedef struct packed {
        logic        sgn;
        logic [9:0]  ex;
        logic [47:0] mag;
        logic        zero;
        logic        inf;
        logic        nan;
    } t_mul_mid;

    // Round a positive significand m (leading one at bit 47 or 46) with a biased
    // exponent e for value m * 2^(e-127-46); returns final bits.
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [47:0] m);
        logic signed [11:0] ee;
        logic [49:0] mm;
        logic [5:0]  sh;
        logic [25:0] keep;
        logic        sticky;
        logic [24:0] q;
        logic [31:0] res;
        ee = e;
        mm = {m, 2'b00};
        if (m[47]) begin
            ee = e + 12'sd1;
        end else begin
            mm = {m[46:0], 3'b000};
        end
        // mm[49] is leading one; mantissa mm[48:26], guard mm[25].
        if (ee <= 0) begin
            sh = (ee < -12'sd26) ? 6'd27 : 6'(12'sd1 - ee);
            sticky = 1'b0;
            for (int i = 0; i < 50; i++) begin
                if (i < int'(sh)) sticky = sticky | mm[i];
            end
            mm = mm >> sh;
            ee = 12'sd0;
        end else begin
            sticky = 1'b0;
        end
        keep = mm[49:24];
        sticky = sticky | (|mm[23:0]);
        q = {1'b0, keep[25:2]};
        if (keep[1] && (keep[0] || sticky || keep[2])) q = q + 25'd1;
        if (ee == 0) begin
            res = {s, 8'(q[23] ? 1 : 0), q[22:0]};
        end else begin
            if (q[24]) ee = ee + 12'sd1;
            if (ee >= 12'sd255) res = {s, 8'hff, 23'd0};
            else res = {s, ee[7:0], q[24] ? q[23:1] : q[22:0]};
        end
        return res;
    endfunction
endpackage

// ===== rtl/fisqrt_fmul.sv =====
// Two stage single precision multiplier with round to nearest even.
// Depends on fisqrt_pkg.
module fisqrt_fmul import fisqrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);
    t_mul_mid r_mid;
    t_mul_mid n_mid;
    logic [31:0] r_p;

    function automatic logic [31:0] round_pack_norm(input t_mul_mid m);
        logic [47:0] v;
        logic signed [11:0] e;
        v = m.mag;
        e = 12'(signed'({2'b0, m.ex})) - 12'sd127;
        for (int i = 0; i < 6; i++) begin
            if (!v[47] && !v[46]) begin
                v = v << 1;
                e = e - 12'sd1;
            end
        end
        for (int i = 0; i < 6; i++) begin
            if (!v[47] && !v[46] && !v[45] && !v[44]) begin
                v = v << 4;
                e = e - 12'sd4;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (!v[47] && !v[46]) begin
                v = v << 1;
                e = e - 12'sd1;
            end
        end
        return round_pack(m.sgn, e, v);
    endfunction

    always_comb begin
        logic [7:0] ea, eb;
        logic [23:0] ma, mb;
        logic na, nb, ia, ib, za, zb;
        ea = i_a[30:23];
        eb = i_b[30:23];
        ma = {ea != 0, i_a[22:0]};
        mb = {eb != 0, i_b[22:0]};
        na = (ea == 8'hff) && (i_a[22:0] != 0);
        nb = (eb == 8'hff) && (i_b[22:0] != 0);
        ia = (ea == 8'hff) && (i_a[22:0] == 0);
        ib = (eb == 8'hff) && (i_b[22:0] == 0);
        za = (i_a[30:0] == 0);
        zb = (i_b[30:0] == 0);
        n_mid.sgn = i_a[31] ^ i_b[31];
        n_mid.ex = 10'({2'b0, (ea == 0) ? 8'd1 : ea}) + 10'({2'b0, (eb == 0) ? 8'd1 : eb});
        n_mid.mag = ma * mb;
        n_mid.nan = na || nb || (ia && zb) || (ib && za);
        n_mid.inf = ia || ib;
        n_mid.zero = za || zb;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
            if (r_mid.nan) r_p <= CANON_NAN;
            else if (r_mid.inf) r_p <= {r_mid.sgn, 8'hff, 23'd0};
            else if (r_mid.zero || r_mid.mag == 0) r_p <= {r_mid.sgn, 31'd0};
            else r_p <= round_pack_norm(r_mid);
        end
    end

    assign o_p = r_p;
endmodule

// ===== rtl/fisqrt_fsub.sv =====
// Two stage subtractor computing 1.5 minus t in single precision.
// Depends on fisqrt_pkg.
module fisqrt_fsub import fisqrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_t,
    output logic [31:0] o_d
);
    logic        r_spec;
    logic [31:0] r_spec_val;
    logic        r_sgn;
    logic [7:0]  r_eb;
    logic [51:0] r_sum;
    logic        n_spec;
    logic [31:0] n_spec_val;
    logic        n_sgn;
    logic [7:0]  n_eb;
    logic [51:0] n_sum;
    logic [31:0] r_d;

    function automatic logic [31:0] norm_round(input logic s, input logic [7:0] eb,
                                               input logic [51:0] sum);
        logic [5:0]  lead;
        logic [47:0] m;
        logic signed [11:0] e;
        lead = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (sum[i]) lead = 6'(i);
        end
        if (lead >= 6'd46) begin
            m = 48'(sum >> (lead - 6'd46));
            m[0] = m[0] | (|(sum & ~({52{1'b1}} << (lead - 6'd46))));
        end else begin
            m = 48'(sum << (6'd46 - lead));
        end
        e = $signed({4'b0, eb}) + $signed({6'b0, lead}) - 12'sd50;
        return round_pack(s, e, m);
    endfunction

    // The larger magnitude sits at bits 50:27, the aligned smaller one below it,
    // and bit 0 keeps the sticky of the bits shifted out.
    always_comb begin
        logic [7:0]  et;
        logic [23:0] mt;
        logic        t_big;
        logic [23:0] sig_big;
        logic [23:0] sig_low;
        logic [7:0]  shamt;
        logic [5:0]  shamt_c;
        logic [49:0] full_al;
        logic [49:0] shifted;
        logic        lost;
        logic [51:0] op_big;
        logic [51:0] op_low;
        et = i_t[30:23];
        mt = {et != 8'd0, i_t[22:0]};
        t_big = i_t[30:0] > THREE_HALVES_F[30:0];
        if (t_big) begin
            sig_big = mt;
            sig_low = {1'b1, THREE_HALVES_F[22:0]};
            n_eb = et;
            shamt = et - THREE_HALVES_F[30:23];
        end else begin
            sig_big = {1'b1, THREE_HALVES_F[22:0]};
            sig_low = mt;
            n_eb = THREE_HALVES_F[30:23];
            shamt = THREE_HALVES_F[30:23] - ((et == 8'd0) ? 8'd1 : et);
        end
        shamt_c = (shamt > 8'd50) ? 6'd50 : shamt[5:0];
        full_al = {sig_low, 26'b0};
        shifted = full_al >> shamt_c;
        lost = |(full_al & ~({50{1'b1}} << shamt_c));
        op_big = {1'b0, sig_big, 27'b0};
        op_low = {1'b0, shifted, lost};
        n_sum = i_t[31] ? (op_big + op_low) : (op_big - op_low);
        n_sgn = t_big ? ~i_t[31] : 1'b0;
        n_spec = (et == 8'hff);
        n_spec_val = (i_t[22:0] != 0) ? CANON_NAN : {~i_t[31], 8'hff, 23'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec <= n_spec;
            r_spec_val <= n_spec_val;
            r_sgn <= n_sgn;
            r_eb <= n_eb;
            r_sum <= n_sum;
            if (r_spec) r_d <= r_spec_val;
            else if (r_sum == '0) r_d <= '0;
            else r_d <= norm_round(r_sgn, r_eb, r_sum);
        end
    end

    assign o_d = r_d;
endmodule

// ===== rtl/fast_inverse_sqrt_f32_unit.sv =====
// Fast inverse square root, one Newton step, single precision.
// Accepts one word per cycle while o_stall is low; each float unit is two stages.
// The pipeline advances whenever the output register is empty or taken.
// Synchronous active low reset clears the valid bits only.
`include "assert_macros.svh"
module fast_inverse_sqrt_f32_unit import fisqrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_bits
);
    logic [LATENCY-1:0] r_vld;
    logic adv;
    logic [31:0] r_x, r_seed0, r_seed1, r_seed2, r_seed3, r_seed4, r_seed5, r_seed6;
    logic [31:0] r_seed7, r_seed8;
    logic [31:0] half, p, tt, d, rr;

    assign adv = !(r_vld[LATENCY-1] && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[LATENCY-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x <= i_operand_bits;
            r_seed0 <= MAGIC_SEED - {1'b0, i_operand_bits[31:1]};
            r_seed1 <= r_seed0;
            r_seed2 <= r_seed1;
            r_seed3 <= r_seed2;
            r_seed4 <= r_seed3;
            r_seed5 <= r_seed4;
            r_seed6 <= r_seed5;
            r_seed7 <= r_seed6;
            r_seed8 <= r_seed7;
        end
    end

    fisqrt_fmul u_half (.i_clk(i_clk), .i_en(adv), .i_a(r_x), .i_b(HALF_F), .o_p(half));
    fisqrt_fmul u_p (.i_clk(i_clk), .i_en(adv), .i_a(half), .i_b(r_seed2), .o_p(p));
    fisqrt_fmul u_t (.i_clk(i_clk), .i_en(adv), .i_a(p), .i_b(r_seed4), .o_p(tt));
    fisqrt_fsub u_d (.i_clk(i_clk), .i_en(adv), .i_t(tt), .o_d(d));
    fisqrt_fmul u_r (.i_clk(i_clk), .i_en(adv), .i_a(r_seed8), .i_b(d), .o_p(rr));

    assign o_valid = r_vld[LATENCY-1];
    assign o_result_bits = rr;

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result_bits))
    `ASSERT_IMPLIES(a_stall, i_clk, i_rst_n, o_stall, o_valid)
endmodule
